>>> design/fixed_point_stack_expression_evaluator_top_defines.svh
// Assertion helpers shared by the checker files of the expression evaluator.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef FIXED_POINT_STACK_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH
`define FIXED_POINT_STACK_EXPRESSION_EVALUATOR_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define FPSE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fpse: same-cycle assertion failed");

// Consequent checked in the cycle after the antecedent.
`define FPSE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fpse: next-cycle assertion failed");

`endif

>>> design/fpse_pkg.sv
// ----------------------------------------------------------------------------
// fpse_pkg
// Instruction codes and instruction helpers of the stack expression evaluator.
// ----------------------------------------------------------------------------
package fpse_pkg;

    localparam logic [5:0] M_END     = 6'd0;
    localparam logic [5:0] M_PUSH8   = 6'd1;
    localparam logic [5:0] M_PUSH16  = 6'd2;
    localparam logic [5:0] M_PUSHFX  = 6'd3;
    localparam logic [5:0] M_TRG     = 6'd4;
    localparam logic [5:0] M_CMD     = 6'd5;
    localparam logic [5:0] M_UNSUP   = 6'd6;
    localparam logic [5:0] M_ANDJ    = 6'd7;
    localparam logic [5:0] M_ORJ     = 6'd8;
    localparam logic [5:0] M_BOOL    = 6'd9;
    localparam logic [5:0] M_NEG     = 6'd10;
    localparam logic [5:0] M_NOT     = 6'd11;
    localparam logic [5:0] M_BNOT    = 6'd12;
    localparam logic [5:0] M_ABS     = 6'd13;
    localparam logic [5:0] M_FLOOR   = 6'd14;
    localparam logic [5:0] M_INRANGE = 6'd15;
    localparam logic [5:0] M_IFELSE  = 6'd16;
    localparam logic [5:0] M_ADD     = 6'd17;
    localparam logic [5:0] M_SUB     = 6'd18;
    localparam logic [5:0] M_MUL     = 6'd19;
    localparam logic [5:0] M_DIV     = 6'd20;
    localparam logic [5:0] M_MOD     = 6'd21;
    localparam logic [5:0] M_POW     = 6'd22;
    localparam logic [5:0] M_EQ      = 6'd23;
    localparam logic [5:0] M_NE      = 6'd24;
    localparam logic [5:0] M_LT      = 6'd25;
    localparam logic [5:0] M_LE      = 6'd26;
    localparam logic [5:0] M_GT      = 6'd27;
    localparam logic [5:0] M_GE      = 6'd28;
    localparam logic [5:0] M_BAND    = 6'd29;
    localparam logic [5:0] M_BOR     = 6'd30;
    localparam logic [5:0] M_BXOR    = 6'd31;
    localparam logic [5:0] M_LAND    = 6'd32;
    localparam logic [5:0] M_LOR     = 6'd33;
    localparam logic [5:0] M_LXOR    = 6'd34;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW = 2'd3;

    // Encoded byte length of an instruction, used while skipping.
    function automatic logic [2:0] item_bytes(input logic [5:0] m);
        logic [2:0] len;
        case (m)
            M_PUSH8, M_TRG, M_CMD, M_UNSUP, M_INRANGE: len = 3'd2;
            M_PUSH16, M_ANDJ, M_ORJ:                    len = 3'd3;
            M_PUSHFX:                                   len = 3'd5;
            default:                                    len = 3'd1;
        endcase
        return len;
    endfunction

    // Number of stack words an instruction consumes.
    function automatic logic [1:0] operands_needed(input logic [5:0] m);
        logic [1:0] n;
        if (m <= M_UNSUP) begin
            n = 2'd0;
        end else if (m <= M_FLOOR) begin
            n = 2'd1;
        end else if (m <= M_IFELSE) begin
            n = 2'd3;
        end else begin
            n = 2'd2;
        end
        return n;
    endfunction

endpackage

>>> design/fpse_in_if.sv
// ----------------------------------------------------------------------------
// fpse_in_if
// Instruction channel: one decoded bytecode instruction per item.
// ----------------------------------------------------------------------------
interface fpse_in_if;
    logic               valid;
    logic               ready;
    logic        [5:0]  mode;
    logic signed [31:0] operand_value;
    logic        [15:0] jump_bytes;
    logic        [1:0]  bound_flags;

    modport source (output valid, mode, operand_value, jump_bytes, bound_flags,
                    input ready);
    modport sink   (input valid, mode, operand_value, jump_bytes, bound_flags,
                    output ready);
endinterface

>>> design/fpse_out_if.sv
// ----------------------------------------------------------------------------
// fpse_out_if
// Result channel: one evaluated expression value with its status per item.
// ----------------------------------------------------------------------------
interface fpse_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic        [1:0]  status;

    modport source (output valid, result_value, status, input ready);
    modport sink   (input valid, result_value, status, output ready);
endinterface

>>> design/fixed_point_stack_expression_evaluator_top.sv
// ----------------------------------------------------------------------------
// fixed_point_stack_expression_evaluator_top
// Stack machine that evaluates decoded bytecode on signed fixed-point words.
// ----------------------------------------------------------------------------
// One item is taken at a time. A push item is written to the stack straight
// from the idle state, and an end item passes through the end state, which
// waits while the previous result is still in the output register.
// An item that works on the stack is issued, reads its one to three operands
// from the stack memory one word a cycle, and then executes. Multiply goes on
// through a two-pass 32x16 multiplier, and divide and mod through a
// one-bit-per-cycle divider. Power reuses the multiplier: for an integral
// base it takes up to two multiplies per exponent bit, otherwise one multiply
// per unit of the exponent until the product stops changing. Skipped and
// ignored items are consumed straight from the idle state. A result waiting
// in the output register never stalls the next item unless that item is
// itself an end.
module fixed_point_stack_expression_evaluator_top
    import fpse_pkg::*;
#(
    parameter int STACK_DEPTH   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpse_in_if.sink     i_in,
    fpse_out_if.source  o_out
);

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int DEPW = $clog2(STACK_DEPTH + 1);
    localparam int DW   = 32 + FRACTION_BITS;
    localparam int CW   = $clog2(DW + 1);
    localparam logic [31:0] FX_ONE  = 32'(1) << FRACTION_BITS;
    localparam logic [31:0] FX_MASK = FX_ONE - 32'(1);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_END  = 14'b00000000000010,
        S_F1   = 14'b00000000000100,
        S_F2   = 14'b00000000001000,
        S_F3   = 14'b00000000010000,
        S_EXEC = 14'b00000000100000,
        S_MUL1 = 14'b00000001000000,
        S_MUL2 = 14'b00000010000000,
        S_MUL3 = 14'b00000100000000,
        S_MULD = 14'b00001000000000,
        S_DIV  = 14'b00010000000000,
        S_DIVD = 14'b00100000000000,
        S_PI   = 14'b01000000000000,
        S_PF   = 14'b10000000000000
    } t_state;

    typedef enum logic [1:0] {
        MK_FX     = 2'd0,
        MK_PI_ACC = 2'd1,
        MK_PI_SQ  = 2'd2,
        MK_PF     = 2'd3
    } t_mul_kind;

    t_state    r_state;
    t_mul_kind r_kind;

    // Stack memory with a registered read and write-to-read forwarding.
    logic [31:0]     r_stack [STACK_DEPTH];
    logic [31:0]     r_rd;
    logic [AW-1:0]   rd_addr;
    logic            r_we;
    logic [AW-1:0]   r_waddr;
    logic [31:0]     r_wdata;

    logic [DEPW-1:0] r_depth;
    logic [15:0]     r_skip;
    logic [1:0]      r_abort;

    logic [5:0]      r_mode;
    logic [15:0]     r_jump;
    logic [1:0]      r_flags;
    logic [1:0]      r_need;
    logic [AW-1:0]   r_wb;
    logic [31:0]     r_a, r_b, r_c;

    logic            r_out_valid;
    logic [31:0]     r_out_value;
    logic [1:0]      r_out_status;
    logic            r_end_top;

    // Multiplier operands, partial products and product.
    logic [31:0]        r_ma, r_mb;
    logic signed [48:0] r_p0;
    logic signed [47:0] r_p1;
    logic [63:0]        r_prod;
    logic [31:0]        prod_fx;

    // Divider state.
    logic [31:0]   r_rem;
    logic [DW-1:0] r_quo;
    logic [31:0]   r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_neg;
    logic          r_is_mod;
    logic [32:0]   rem_sh;
    logic          div_fits;

    // Power loop state.
    logic [31:0]   r_acc, r_m, r_n;

    logic [5:0]    in_mode;
    logic [1:0]    in_need;
    logic [2:0]    in_len;
    logic [31:0]   alu_res;
    logic [31:0]   ia_s, ib_s;
    logic [31:0]   ua, ub, mag_ia, mag_ib;
    logic          in_ok;
    logic [31:0]   div_q, mod_r;

    assign in_mode = i_in.mode;
    assign in_need = operands_needed(in_mode);
    assign in_len  = item_bytes(in_mode);

    assign i_in.ready         = (r_state == S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.result_value = r_out_value;
    assign o_out.status       = r_out_status;

    always_comb begin
        case (r_state)
            S_F1:    rd_addr = AW'(r_depth - DEPW'(2));
            S_F2:    rd_addr = AW'(r_depth - DEPW'(3));
            default: rd_addr = AW'(r_depth - DEPW'(1));
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_stack[r_waddr] <= r_wdata;
        end
        if (r_we && (r_waddr == rd_addr)) begin
            r_rd <= r_wdata;
        end else begin
            r_rd <= r_stack[rd_addr];
        end
    end

    // Integer parts and magnitudes for mod, divide and power.
    assign ia_s   = 32'($signed(r_a) >>> FRACTION_BITS);
    assign ib_s   = 32'($signed(r_b) >>> FRACTION_BITS);
    assign ua     = r_a[31] ? (32'd0 - r_a) : r_a;
    assign ub     = r_b[31] ? (32'd0 - r_b) : r_b;
    assign mag_ia = ia_s[31] ? (32'd0 - ia_s) : ia_s;
    assign mag_ib = ib_s[31] ? (32'd0 - ib_s) : ib_s;

    assign in_ok = (r_flags[0] ? ($signed(r_c) >= $signed(r_a)) : ($signed(r_c) > $signed(r_a)))
                && (r_flags[1] ? ($signed(r_c) <= $signed(r_b)) : ($signed(r_c) < $signed(r_b)));

    // Combinational operations. The top word is r_b; r_a lies below it.
    always_comb begin
        case (r_mode)
            M_BOOL:    alu_res = (r_b != 32'd0) ? FX_ONE : 32'd0;
            M_NEG:     alu_res = 32'd0 - r_b;
            M_NOT:     alu_res = (r_b == 32'd0) ? FX_ONE : 32'd0;
            M_BNOT:    alu_res = ~r_b & ~FX_MASK;
            M_ABS:     alu_res = r_b[31] ? (32'd0 - r_b) : r_b;
            M_FLOOR:   alu_res = r_b & ~FX_MASK;
            M_INRANGE: alu_res = in_ok ? FX_ONE : 32'd0;
            M_IFELSE:  alu_res = (r_c != 32'd0) ? r_a : r_b;
            M_ADD:     alu_res = r_a + r_b;
            M_SUB:     alu_res = r_a - r_b;
            M_EQ:      alu_res = (r_a == r_b) ? FX_ONE : 32'd0;
            M_NE:      alu_res = (r_a != r_b) ? FX_ONE : 32'd0;
            M_LT:      alu_res = ($signed(r_a) <  $signed(r_b)) ? FX_ONE : 32'd0;
            M_LE:      alu_res = ($signed(r_a) <= $signed(r_b)) ? FX_ONE : 32'd0;
            M_GT:      alu_res = ($signed(r_a) >  $signed(r_b)) ? FX_ONE : 32'd0;
            M_GE:      alu_res = ($signed(r_a) >= $signed(r_b)) ? FX_ONE : 32'd0;
            M_BAND:    alu_res = (r_a & r_b) & ~FX_MASK;
            M_BOR:     alu_res = (r_a | r_b) & ~FX_MASK;
            M_BXOR:    alu_res = (r_a ^ r_b) & ~FX_MASK;
            M_LAND:    alu_res = ((r_a != 32'd0) && (r_b != 32'd0)) ? FX_ONE : 32'd0;
            M_LOR:     alu_res = ((r_a != 32'd0) || (r_b != 32'd0)) ? FX_ONE : 32'd0;
            default:   alu_res = ((r_a != 32'd0) != (r_b != 32'd0)) ? FX_ONE : 32'd0;
        endcase
    end

    assign prod_fx  = r_prod[FRACTION_BITS+31:FRACTION_BITS];
    assign rem_sh   = {r_rem, r_quo[DW-1]};
    assign div_fits = (rem_sh >= {1'b0, r_dvs});
    assign div_q    = r_neg ? (32'd0 - r_quo[31:0]) : r_quo[31:0];
    assign mod_r    = (r_neg ? (32'd0 - r_rem) : r_rem) << FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kind      <= MK_FX;
            r_we        <= 1'b0;
            r_depth     <= '0;
            r_skip      <= '0;
            r_abort     <= ST_OK;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_we <= 1'b0;
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_mode  <= in_mode;
                        r_jump  <= i_in.jump_bytes;
                        r_flags <= i_in.bound_flags;
                        r_need  <= in_need;
                        r_wb    <= AW'(r_depth - DEPW'(in_need));
                        if (in_mode == M_END) begin
                            r_end_top <= (r_abort == ST_OK) && (r_depth != '0);
                            r_state   <= S_END;
                        end else if (r_abort != ST_OK) begin
                            r_state <= S_IDLE;
                        end else if (r_skip != 16'd0) begin
                            r_skip <= (16'(in_len) >= r_skip) ? 16'd0 : r_skip - 16'(in_len);
                        end else if (in_mode > M_LXOR) begin
                            r_abort <= ST_INVALID;
                        end else if (r_depth < DEPW'(in_need)) begin
                            r_abort <= ST_UNDERFLOW;
                        end else if (in_need == 2'd0) begin
                            r_we    <= 1'b1;
                            r_waddr <= AW'(r_depth);
                            r_wdata <= (in_mode == M_UNSUP) ? 32'd0 : i_in.operand_value;
                            r_depth <= r_depth + DEPW'(1);
                            if ((r_depth + DEPW'(1)) >= DEPW'(STACK_DEPTH)) begin
                                r_abort <= ST_OVERFLOW;
                                r_skip  <= 16'd0;
                            end
                        end else begin
                            r_state <= S_F1;
                        end
                    end
                end
                S_END: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_value  <= r_end_top ? r_rd : 32'd0;
                        r_out_status <= r_abort;
                        r_depth      <= '0;
                        r_skip       <= 16'd0;
                        r_abort      <= ST_OK;
                        r_state      <= S_IDLE;
                    end
                end
                S_F1: begin
                    r_b     <= r_rd;
                    r_state <= (r_need == 2'd1) ? S_EXEC : S_F2;
                end
                S_F2: begin
                    r_a     <= r_rd;
                    r_state <= (r_need == 2'd2) ? S_EXEC : S_F3;
                end
                S_F3: begin
                    r_c     <= r_rd;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    case (r_mode)
                        M_ANDJ: begin
                            if (r_b == 32'd0) begin
                                r_skip <= r_jump;
                            end else begin
                                r_depth <= r_depth - DEPW'(1);
                            end
                        end
                        M_ORJ: begin
                            if (r_b != 32'd0) begin
                                r_we    <= 1'b1;
                                r_waddr <= r_wb;
                                r_wdata <= FX_ONE;
                                r_skip  <= r_jump;
                            end else begin
                                r_depth <= r_depth - DEPW'(1);
                            end
                        end
                        M_MUL: begin
                            r_ma    <= r_a;
                            r_mb    <= r_b;
                            r_kind  <= MK_FX;
                            r_state <= S_MUL1;
                        end
                        M_DIV, M_MOD: begin
                            if ((r_mode == M_DIV) ? (r_b == 32'd0) : (ib_s == 32'd0)) begin
                                r_we    <= 1'b1;
                                r_waddr <= r_wb;
                                r_wdata <= 32'd0;
                                r_depth <= DEPW'(r_wb) + DEPW'(1);
                            end else begin
                                r_is_mod <= (r_mode == M_MOD);
                                r_rem    <= 32'd0;
                                r_cnt    <= CW'(DW);
                                r_state  <= S_DIV;
                                if (r_mode == M_DIV) begin
                                    r_quo <= {ua, {FRACTION_BITS{1'b0}}};
                                    r_dvs <= ub;
                                    r_neg <= r_a[31] ^ r_b[31];
                                end else begin
                                    r_quo <= DW'(mag_ia);
                                    r_dvs <= mag_ib;
                                    r_neg <= ia_s[31];
                                end
                            end
                        end
                        M_POW: begin
                            r_n <= ib_s;
                            if (ib_s[31] || (ib_s == 32'd0)) begin
                                r_we    <= 1'b1;
                                r_waddr <= r_wb;
                                r_wdata <= FX_ONE;
                                r_depth <= DEPW'(r_wb) + DEPW'(1);
                            end else if ((r_a & FX_MASK) == 32'd0) begin
                                r_m     <= ia_s;
                                r_acc   <= 32'd1;
                                r_state <= S_PI;
                            end else begin
                                r_acc   <= FX_ONE;
                                r_state <= S_PF;
                            end
                        end
                        default: begin
                            r_we    <= 1'b1;
                            r_waddr <= r_wb;
                            r_wdata <= alu_res;
                            r_depth <= DEPW'(r_wb) + DEPW'(1);
                        end
                    endcase
                end
                S_MUL1: begin
                    r_p0    <= $signed(r_ma) * $signed({1'b0, r_mb[15:0]});
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p1    <= $signed(r_ma) * $signed(r_mb[31:16]);
                    r_state <= S_MUL3;
                end
                S_MUL3: begin
                    r_prod  <= {{15{r_p0[48]}}, r_p0} + {r_p1, 16'd0};
                    r_state <= S_MULD;
                end
                S_MULD: begin
                    case (r_kind)
                        MK_FX: begin
                            r_we    <= 1'b1;
                            r_waddr <= r_wb;
                            r_wdata <= prod_fx;
                            r_depth <= DEPW'(r_wb) + DEPW'(1);
                            r_state <= S_IDLE;
                        end
                        MK_PI_ACC: begin
                            r_acc   <= r_prod[31:0];
                            r_ma    <= r_m;
                            r_mb    <= r_m;
                            r_kind  <= MK_PI_SQ;
                            r_state <= S_MUL1;
                        end
                        MK_PI_SQ: begin
                            r_m     <= r_prod[31:0];
                            r_n     <= r_n >> 1;
                            r_state <= S_PI;
                        end
                        default: begin
                            if (prod_fx == r_acc) begin
                                r_n <= 32'd0;
                            end else begin
                                r_acc <= prod_fx;
                                r_n   <= r_n - 32'd1;
                            end
                            r_state <= S_PF;
                        end
                    endcase
                end
                S_PI: begin
                    if (r_n == 32'd0) begin
                        r_we    <= 1'b1;
                        r_waddr <= r_wb;
                        r_wdata <= r_acc << FRACTION_BITS;
                        r_depth <= DEPW'(r_wb) + DEPW'(1);
                        r_state <= S_IDLE;
                    end else begin
                        r_ma    <= r_n[0] ? r_acc : r_m;
                        r_mb    <= r_m;
                        r_kind  <= r_n[0] ? MK_PI_ACC : MK_PI_SQ;
                        r_state <= S_MUL1;
                    end
                end
                S_PF: begin
                    if (r_n == 32'd0) begin
                        r_we    <= 1'b1;
                        r_waddr <= r_wb;
                        r_wdata <= r_acc;
                        r_depth <= DEPW'(r_wb) + DEPW'(1);
                        r_state <= S_IDLE;
                    end else begin
                        r_ma    <= r_acc;
                        r_mb    <= r_a;
                        r_kind  <= MK_PF;
                        r_state <= S_MUL1;
                    end
                end
                S_DIV: begin
                    r_rem <= div_fits ? 32'(rem_sh - {1'b0, r_dvs}) : rem_sh[31:0];
                    r_quo <= {r_quo[DW-2:0], div_fits};
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        r_state <= S_DIVD;
                    end
                end
                S_DIVD: begin
                    r_we    <= 1'b1;
                    r_waddr <= r_wb;
                    r_wdata <= r_is_mod ? mod_r : div_q;
                    r_depth <= DEPW'(r_wb) + DEPW'(1);
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/fpse_checker.sv
// ----------------------------------------------------------------------------
// fpse_checker
// Port-level checks of the expression evaluator, bound to its top level.
// ----------------------------------------------------------------------------
`include "fixed_point_stack_expression_evaluator_top_defines.svh"

module fpse_checker
    import fpse_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [5:0]  i_in_mode,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_out_value,
    input logic [1:0]  i_out_status
);

    // A stalled result keeps its value and status.
    `FPSE_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_value) && $stable(i_out_status))

    // An aborted program always reports a zero value.
    `FPSE_ASSERT_NOW(a_abort_zero, i_out_valid && (i_out_status != ST_OK), i_out_value == 32'd0)

    // An accepted end item blocks the input while its result is produced.
    `FPSE_ASSERT_NEXT(a_end_busy, i_in_valid && i_in_ready && (i_in_mode == M_END), !i_in_ready)

    // A new result only appears from the end state, never while idle.
    `FPSE_ASSERT_NOW(a_out_from_end, $rose(i_out_valid), $past(!i_in_ready))

endmodule

bind fixed_point_stack_expression_evaluator_top fpse_checker u_fpse_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_mode    (i_in.mode),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_value  (o_out.result_value),
    .i_out_status (o_out.status)
);
